FILE: src/ifd_pkg.sv
`timescale 1ns / 1ps

package ifd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK
  } ifd_state_e;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  localparam logic [3:0] ACT_UPDATED   = 4'd0;
  localparam logic [3:0] ACT_SHORT     = 4'd1;
  localparam logic [3:0] ACT_BADSUM    = 4'd2;
  localparam logic [3:0] ACT_LOCAL_IGN = 4'd3;
  localparam logic [3:0] ACT_ECHO      = 4'd4;
  localparam logic [3:0] ACT_PORT_UNR  = 4'd5;
  localparam logic [3:0] ACT_TTL_EXC   = 4'd6;
  localparam logic [3:0] ACT_NET_UNR   = 4'd7;
  localparam logic [3:0] ACT_FORWARD   = 4'd8;

  localparam logic [15:0] MIN_FRAME     = 16'd34;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;

  localparam logic [2:0] REG_PORT_ADDR_0 = 3'd0;
  localparam logic [2:0] REG_PORT_ADDR_1 = 3'd1;
  localparam logic [2:0] REG_PORT_ADDR_2 = 3'd2;
  localparam logic [2:0] REG_PORT_ADDR_3 = 3'd3;
  localparam logic [2:0] REG_PORTS_IN_USE = 3'd4;

  localparam logic [2:0] PORTS_IN_USE_RESET = 3'd4;

  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [1:0]  port;
  } route_entry_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } route_cmd_t;

  typedef struct packed {
    logic        sum_ok;
    logic [15:0] new_sum;
    logic [7:0]  ttl_dec;
    logic [7:0]  proto;
  } hdr_info_t;

endpackage

FILE: src/ifd_route_mem.sv
`timescale 1ns / 1ps

module ifd_route_mem #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ifd_pkg::route_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  ifd_pkg::route_entry_t wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output ifd_pkg::route_entry_t rdata_o,
  output logic                  rvalid_o
);
  import ifd_pkg::*;

  route_entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  route_entry_t rdata_q;
  logic rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // The valid bit is read alongside the entry so both arrive in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        valid_q[waddr_i] <= 1'b1;
      end else if (cmd_i.clr) begin
        valid_q[waddr_i] <= 1'b0;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

FILE: src/ifd_hdr_check.sv
`timescale 1ns / 1ps

module ifd_hdr_check (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [63:0]         hdr_bytes_0_7_i,
  input  logic [63:0]         hdr_bytes_8_15_i,
  input  logic [31:0]         hdr_bytes_16_19_i,
  output ifd_pkg::hdr_info_t  info_o
);
  import ifd_pkg::*;

  logic [7:0]  ttl_in;
  logic [7:0]  ttl_dec;
  logic [7:0]  proto;
  logic [19:0] sum_common;
  logic [19:0] sum_old_d;
  logic [19:0] sum_new_d;
  logic [19:0] sum_old_q;
  logic [19:0] sum_new_q;
  logic [15:0] rx_sum_q;
  logic [7:0]  ttl_dec_q;
  logic [7:0]  proto_q;
  logic [16:0] old_f1;
  logic [15:0] old_f2;
  logic [16:0] new_f1;
  logic [15:0] new_f2;

  assign ttl_in  = hdr_bytes_8_15_i[63:56];
  assign proto   = hdr_bytes_8_15_i[55:48];
  assign ttl_dec = ttl_in - 8'd1;

  // Eight words shared by both sums; the checksum word itself counts as zero.
  assign sum_common = 20'(hdr_bytes_0_7_i[63:48]) + 20'(hdr_bytes_0_7_i[47:32])
                    + 20'(hdr_bytes_0_7_i[31:16]) + 20'(hdr_bytes_0_7_i[15:0])
                    + 20'(hdr_bytes_8_15_i[31:16]) + 20'(hdr_bytes_8_15_i[15:0])
                    + 20'(hdr_bytes_16_19_i[31:16]) + 20'(hdr_bytes_16_19_i[15:0]);
  assign sum_old_d = sum_common + 20'({ttl_in, proto});
  assign sum_new_d = sum_common + 20'({ttl_dec, proto});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_old_q <= sum_old_d;
      sum_new_q <= sum_new_d;
      rx_sum_q  <= hdr_bytes_8_15_i[47:32];
      ttl_dec_q <= ttl_dec;
      proto_q   <= proto;
    end
  end

  // Two end-around carry folds bring a sum of nine words back to 16 bits.
  assign old_f1 = 17'(sum_old_q[15:0]) + 17'(sum_old_q[19:16]);
  assign old_f2 = old_f1[15:0] + 16'(old_f1[16]);
  assign new_f1 = 17'(sum_new_q[15:0]) + 17'(sum_new_q[19:16]);
  assign new_f2 = new_f1[15:0] + 16'(new_f1[16]);

  assign info_o.sum_ok  = (~old_f2) == rx_sum_q;
  assign info_o.new_sum = ~new_f2;
  assign info_o.ttl_dec = ttl_dec_q;
  assign info_o.proto   = proto_q;

endmodule

FILE: src/ipv4_forward_decision_core.sv
`timescale 1ns / 1ps

// IPv4 forwarding decision core. An item is taken when start is high and busy is low.
// Route writes and clears, short frames and the unused opcode finish in the cycle of the
// transfer; a route update or short-frame result appears on the next cycle. A header
// classification first runs the checksum and local-address checks in ST_CHECK, where a
// bad checksum, local delivery or TTL expiry is decided and registered as the result.
// Otherwise the route memory is walked one entry per cycle through its single read port,
// and the result is registered once the last entry has been compared; busy is high
// through ST_CHECK and ST_WALK. Each result is shown for exactly one cycle with
// result_valid_o and cannot be held off by the receiver. The route table needs no
// clearing after reset: only the valid bits are reset.
module ipv4_forward_decision_core #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  route_slot_i,
  input  logic [31:0] route_network_i,
  input  logic [31:0] route_netmask_i,
  input  logic [31:0] route_gw_i,
  input  logic [1:0]  route_out_port_i,
  input  logic [1:0]  in_port_i,
  input  logic [15:0] frame_length_i,
  input  logic [63:0] hdr_bytes_0_7_i,
  input  logic [63:0] hdr_bytes_8_15_i,
  input  logic [31:0] hdr_bytes_16_19_i,
  input  logic [7:0]  icmp_kind_i,

  output logic        result_valid_o,
  output logic [3:0]  action_o,
  output logic [1:0]  out_port_o,
  output logic [31:0] hop_addr_o,
  output logic [7:0]  new_ttl_o,
  output logic [15:0] new_checksum_o
);
  import ifd_pkg::*;

  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  ifd_state_e state_q, state_d;

  logic [31:0] port_addr_q [4];
  logic [2:0]  ports_in_use_q;
  logic        cfg_wr;

  logic        valid_q, valid_d;
  logic [3:0]  act_q, act_d;
  logic [1:0]  port_q, port_d;
  logic [31:0] hop_q, hop_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] sum_q, sum_d;

  logic [1:0]  in_port_q;
  logic [31:0] dst_q;
  logic [7:0]  icmp_q;

  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [31:0]      best_mask_q, best_mask_d;
  logic [31:0]      best_gw_q, best_gw_d;
  logic [1:0]       best_port_q, best_port_d;

  logic          accept;
  logic          load_item;
  logic          slot_in_range;
  route_cmd_t    cmd;
  route_entry_t  wdata;
  route_entry_t  rdata;
  logic          rvalid;
  logic [IDX_W-1:0] raddr;
  hdr_info_t     info;
  logic          local_hit;
  logic          hit;
  logic [31:0]   fin_gw;
  logic [1:0]    fin_port;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 4; p++) begin
        port_addr_q[p] <= '0;
      end
      ports_in_use_q <= PORTS_IN_USE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PORT_ADDR_0:  port_addr_q[0] <= pwdata;
        REG_PORT_ADDR_1:  port_addr_q[1] <= pwdata;
        REG_PORT_ADDR_2:  port_addr_q[2] <= pwdata;
        REG_PORT_ADDR_3:  port_addr_q[3] <= pwdata;
        REG_PORTS_IN_USE: ports_in_use_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PORT_ADDR_0:  prdata = port_addr_q[0];
      REG_PORT_ADDR_1:  prdata = port_addr_q[1];
      REG_PORT_ADDR_2:  prdata = port_addr_q[2];
      REG_PORT_ADDR_3:  prdata = port_addr_q[3];
      REG_PORTS_IN_USE: prdata = 32'(ports_in_use_q);
      default:          prdata = '0;
    endcase
  end

  // Item handshake
  assign busy   = state_q != ST_IDLE;
  assign accept = start && !busy;

  assign slot_in_range = 32'(route_slot_i) < 32'(ROUTE_ENTRIES);
  assign wdata.net  = route_network_i;
  assign wdata.mask = route_netmask_i;
  assign wdata.gw   = route_gw_i;
  assign wdata.port = route_out_port_i;

  // Sequential operation means a route write always lands before the next walk reads.
  always_comb begin
    cmd.wr  = accept && (opcode_i == OP_WRITE) && slot_in_range;
    cmd.clr = accept && (opcode_i == OP_CLEAR) && slot_in_range;
  end

  assign load_item = accept && (opcode_i == OP_CLASSIFY);

  ifd_route_mem #(
    .ENTRIES (ROUTE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_route_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .waddr_i  (IDX_W'(route_slot_i)),
    .wdata_i  (wdata),
    .raddr_i  (raddr),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  ifd_hdr_check u_hdr_check (
    .clk_i             (clk_i),
    .load_i            (load_item),
    .hdr_bytes_0_7_i   (hdr_bytes_0_7_i),
    .hdr_bytes_8_15_i  (hdr_bytes_8_15_i),
    .hdr_bytes_16_19_i (hdr_bytes_16_19_i),
    .info_o            (info)
  );

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      in_port_q <= in_port_i;
      dst_q     <= hdr_bytes_16_19_i;
      icmp_q    <= icmp_kind_i;
    end
  end

  // A port counts as local when its index is below the number in use; values above
  // four therefore cover all four ports.
  always_comb begin
    local_hit = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if ((port_addr_q[p] == dst_q) && (3'(p) < ports_in_use_q)) begin
        local_hit = 1'b1;
      end
    end
  end

  // An equal mask still wins, so the later entry takes a tie.
  assign hit = rvalid && ((dst_q & rdata.mask) == (rdata.net & rdata.mask))
               && (rdata.mask >= best_mask_q);
  assign fin_gw   = hit ? rdata.gw : best_gw_q;
  assign fin_port = hit ? rdata.port : best_port_q;

  always_comb begin
    state_d     = state_q;
    valid_d     = 1'b0;
    act_d       = act_q;
    port_d      = port_q;
    hop_d       = hop_q;
    ttl_d       = ttl_q;
    sum_d       = sum_q;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_mask_d = best_mask_q;
    best_gw_d   = best_gw_q;
    best_port_d = best_port_q;
    raddr       = cmp_idx_q + IDX_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          port_d = '0;
          hop_d  = '0;
          ttl_d  = '0;
          sum_d  = '0;
          case (opcode_i)
            OP_WRITE, OP_CLEAR: begin
              valid_d = 1'b1;
              act_d   = ACT_UPDATED;
            end
            OP_CLASSIFY: begin
              if (frame_length_i < MIN_FRAME) begin
                valid_d = 1'b1;
                act_d   = ACT_SHORT;
              end else begin
                state_d = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CHECK: begin
        raddr       = '0;
        cmp_idx_d   = '0;
        found_d     = 1'b0;
        best_mask_d = '0;
        if (!info.sum_ok) begin
          valid_d = 1'b1;
          act_d   = ACT_BADSUM;
          state_d = ST_IDLE;
        end else if (local_hit) begin
          valid_d = 1'b1;
          port_d  = in_port_q;
          state_d = ST_IDLE;
          if (info.proto == PROTO_ICMP) begin
            act_d = (icmp_q == ICMP_ECHO_REQ) ? ACT_ECHO : ACT_LOCAL_IGN;
          end else begin
            act_d = ACT_PORT_UNR;
          end
        end else if (info.ttl_dec == 8'd0) begin
          valid_d = 1'b1;
          act_d   = ACT_TTL_EXC;
          port_d  = in_port_q;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        cmp_idx_d = cmp_idx_q + IDX_W'(1);
        if (hit) begin
          found_d     = 1'b1;
          best_mask_d = rdata.mask;
          best_gw_d   = rdata.gw;
          best_port_d = rdata.port;
        end
        if (cmp_idx_q == IDX_W'(ROUTE_ENTRIES - 1)) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
          ttl_d   = info.ttl_dec;
          sum_d   = info.new_sum;
          if (found_q || hit) begin
            act_d  = ACT_FORWARD;
            port_d = fin_port;
            hop_d  = (fin_gw != 32'd0) ? fin_gw : dst_q;
          end else begin
            act_d  = ACT_NET_UNR;
            port_d = in_port_q;
            hop_d  = '0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    port_q      <= port_d;
    hop_q       <= hop_d;
    ttl_q       <= ttl_d;
    sum_q       <= sum_d;
    cmp_idx_q   <= cmp_idx_d;
    found_q     <= found_d;
    best_mask_q <= best_mask_d;
    best_gw_q   <= best_gw_d;
    best_port_q <= best_port_d;
  end

  assign result_valid_o = valid_q;
  assign action_o       = act_q;
  assign out_port_o     = port_q;
  assign hop_addr_o     = hop_q;
  assign new_ttl_o      = ttl_q;
  assign new_checksum_o = sum_q;

endmodule

FILE: verif/tb_ipv4_forward_decision_core.sv
`timescale 1ns / 1ps

module tb_ipv4_forward_decision_core;
  import ifd_pkg::*;

  localparam int ROUTES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int QUIET_CYCLES = ROUTES + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [1:0]  rport;
    logic [1:0]  in_port;
    logic [15:0] frame_len;
    logic [63:0] hdr_lo;
    logic [63:0] hdr_mid;
    logic [31:0] dst;
    logic [7:0]  icmp_kind;
  } fwd_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  port;
    logic [31:0] hop;
    logic [7:0]  ttl;
    logic [15:0] sum;
  } fwd_decision_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = '0;
  logic [3:0]  route_slot_i = '0;
  logic [31:0] route_network_i = '0;
  logic [31:0] route_netmask_i = '0;
  logic [31:0] route_gw_i = '0;
  logic [1:0]  route_out_port_i = '0;
  logic [1:0]  in_port_i = '0;
  logic [15:0] frame_length_i = '0;
  logic [63:0] hdr_bytes_0_7_i = '0;
  logic [63:0] hdr_bytes_8_15_i = '0;
  logic [31:0] hdr_bytes_16_19_i = '0;
  logic [7:0]  icmp_kind_i = '0;
  logic        result_valid_o;
  logic [3:0]  action_o;
  logic [1:0]  out_port_o;
  logic [31:0] hop_addr_o;
  logic [7:0]  new_ttl_o;
  logic [15:0] new_checksum_o;

  // Shadow of the block's registers and route table.
  logic [31:0] port_addr_m [4];
  logic [2:0]  ports_in_use_m;
  logic [31:0] rt_net [ROUTES];
  logic [31:0] rt_mask [ROUTES];
  logic [31:0] rt_gw [ROUTES];
  logic [1:0]  rt_port [ROUTES];
  bit          rt_valid [ROUTES];
  logic [15:0] prefix_pool [4];

  fwd_decision_t expected_decisions[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  ipv4_forward_decision_core #(
    .ROUTE_ENTRIES(ROUTES)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .route_slot_i     (route_slot_i),
    .route_network_i  (route_network_i),
    .route_netmask_i  (route_netmask_i),
    .route_gw_i       (route_gw_i),
    .route_out_port_i (route_out_port_i),
    .in_port_i        (in_port_i),
    .frame_length_i   (frame_length_i),
    .hdr_bytes_0_7_i  (hdr_bytes_0_7_i),
    .hdr_bytes_8_15_i (hdr_bytes_8_15_i),
    .hdr_bytes_16_19_i(hdr_bytes_16_19_i),
    .icmp_kind_i      (icmp_kind_i),
    .result_valid_o   (result_valid_o),
    .action_o         (action_o),
    .out_port_o       (out_port_o),
    .hop_addr_o       (hop_addr_o),
    .new_ttl_o        (new_ttl_o),
    .new_checksum_o   (new_checksum_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ipv4_forward_decision_core regression: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] %s", $time, msg);
  endtask

  // Header words are summed with the checksum field already zeroed by the caller.
  function automatic logic [15:0] header_checksum(input logic [159:0] hdr);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < 10; i++) acc += hdr[159 - 16 * i -: 16];
    while (acc[31:16] != 16'd0) acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  function automatic bit decide_forwarding(input fwd_item_t it, output fwd_decision_t d);
    logic [159:0] hdr;
    logic [15:0]  rx_sum;
    logic [7:0]   ttl_dec;
    int           nlocal;
    int           best;
    logic [31:0]  best_mask;
    d = '0;
    case (it.opcode)
      OP_WRITE: begin
        rt_net[it.slot] = it.net;
        rt_mask[it.slot] = it.mask;
        rt_gw[it.slot] = it.gw;
        rt_port[it.slot] = it.rport;
        rt_valid[it.slot] = 1'b1;
        d.action = ACT_UPDATED;
        return 1'b1;
      end
      OP_CLEAR: begin
        rt_valid[it.slot] = 1'b0;
        d.action = ACT_UPDATED;
        return 1'b1;
      end
      OP_CLASSIFY: ;
      default: return 1'b0;
    endcase

    if (it.frame_len < MIN_FRAME) begin
      d.action = ACT_SHORT;
      return 1'b1;
    end
    hdr = {it.hdr_lo, it.hdr_mid, it.dst};
    rx_sum = hdr[79:64];
    hdr[79:64] = '0;
    if (header_checksum(hdr) != rx_sum) begin
      d.action = ACT_BADSUM;
      return 1'b1;
    end

    d.port = it.in_port;
    nlocal = (ports_in_use_m > 3'd4) ? 4 : int'(ports_in_use_m);
    for (int p = 0; p < nlocal; p++) begin
      if (port_addr_m[p] == it.dst) begin
        if (hdr[87:80] == PROTO_ICMP)
          d.action = (it.icmp_kind == ICMP_ECHO_REQ) ? ACT_ECHO : ACT_LOCAL_IGN;
        else
          d.action = ACT_PORT_UNR;
        return 1'b1;
      end
    end

    ttl_dec = hdr[95:88] - 8'd1;
    if (ttl_dec == 8'd0) begin
      d.action = ACT_TTL_EXC;
      return 1'b1;
    end
    hdr[95:88] = ttl_dec;
    d.ttl = ttl_dec;
    d.sum = header_checksum(hdr);

    // Equal masks let the higher slot take over, hence the >= comparison.
    best = -1;
    best_mask = '0;
    for (int i = 0; i < ROUTES; i++) begin
      if (rt_valid[i] && ((it.dst & rt_mask[i]) == (rt_net[i] & rt_mask[i]))
          && rt_mask[i] >= best_mask) begin
        best = i;
        best_mask = rt_mask[i];
      end
    end
    if (best < 0) begin
      d.action = ACT_NET_UNR;
      return 1'b1;
    end
    d.action = ACT_FORWARD;
    d.port = rt_port[best];
    d.hop = (rt_gw[best] != 32'd0) ? rt_gw[best] : it.dst;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : result_check
    fwd_decision_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (expected_decisions.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, action %0h", action_o));
      end else begin
        want = expected_decisions.pop_front();
        if (action_o !== want.action)
          flag_mismatch($sformatf("action %0h, expected %0h", action_o, want.action));
        if (out_port_o !== want.port)
          flag_mismatch($sformatf("out_port %0h, expected %0h", out_port_o, want.port));
        if (hop_addr_o !== want.hop)
          flag_mismatch($sformatf("hop_addr %08h, expected %08h", hop_addr_o, want.hop));
        if (new_ttl_o !== want.ttl)
          flag_mismatch($sformatf("new_ttl %0h, expected %0h", new_ttl_o, want.ttl));
        if (new_checksum_o !== want.sum)
          flag_mismatch($sformatf("new_checksum %04h, expected %04h", new_checksum_o,
                                  want.sum));
      end
    end
  end

  // An item transfers at the edge where start is high and busy is low. Start is left
  // high afterwards, so a following item keeps it up without a glitch.
  task automatic send_item(input fwd_item_t it);
    fwd_decision_t d;
    start <= 1'b1;
    opcode_i <= it.opcode;
    route_slot_i <= it.slot;
    route_network_i <= it.net;
    route_netmask_i <= it.mask;
    route_gw_i <= it.gw;
    route_out_port_i <= it.rport;
    in_port_i <= it.in_port;
    frame_length_i <= it.frame_len;
    hdr_bytes_0_7_i <= it.hdr_lo;
    hdr_bytes_8_15_i <= it.hdr_mid;
    hdr_bytes_16_19_i <= it.dst;
    icmp_kind_i <= it.icmp_kind;
    do @(posedge clk_i); while (busy);
    if (decide_forwarding(it, d)) expected_decisions.push_back(d);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Start is dropped and every expected result is drained before a quiet wait follows.
  task automatic wait_for_quiet();
    start <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input bit is_write, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    apb_transfer(1'b1, idx, value, rd);
    if (idx < REG_PORTS_IN_USE) port_addr_m[idx[1:0]] = value;
    else if (idx == REG_PORTS_IN_USE) ports_in_use_m = value[2:0];
    if (idx <= REG_PORTS_IN_USE) begin
      want = (idx < REG_PORTS_IN_USE) ? port_addr_m[idx[1:0]] : {29'd0, ports_in_use_m};
      apb_transfer(1'b0, idx, '0, rd);
      if (rd !== want)
        flag_mismatch($sformatf("register %0d reads %08h, expected %08h", idx, rd, want));
    end
  endtask

  function automatic fwd_item_t noise_item(input logic [1:0] op);
    fwd_item_t it;
    it.opcode = op;
    it.slot = 4'($urandom);
    it.net = $urandom;
    it.mask = $urandom;
    it.gw = $urandom;
    it.rport = 2'($urandom);
    it.in_port = 2'($urandom);
    it.frame_len = 16'($urandom);
    it.hdr_lo = {$urandom, $urandom};
    it.hdr_mid = {$urandom, $urandom};
    it.dst = $urandom;
    it.icmp_kind = 8'($urandom);
    return it;
  endfunction

  function automatic fwd_item_t route_item(input logic [3:0] slot, input logic [31:0] net,
                                           input logic [31:0] mask, input logic [31:0] gw,
                                           input logic [1:0] port);
    fwd_item_t it;
    it = noise_item(OP_WRITE);
    it.slot = slot;
    it.net = net;
    it.mask = mask;
    it.gw = gw;
    it.rport = port;
    return it;
  endfunction

  function automatic fwd_item_t route_clear_of(input logic [3:0] slot);
    fwd_item_t it;
    it = noise_item(OP_CLEAR);
    it.slot = slot;
    return it;
  endfunction

  // A well-formed header with random source and leading bytes and a correct checksum.
  function automatic fwd_item_t make_packet(input logic [7:0] ttl, input logic [7:0] proto,
                                            input logic [7:0] icmp, input logic [31:0] dst,
                                            input logic [15:0] flen);
    fwd_item_t it;
    it = noise_item(OP_CLASSIFY);
    it.hdr_mid[63:48] = {ttl, proto};
    it.hdr_mid[47:32] = '0;
    it.dst = dst;
    it.icmp_kind = icmp;
    it.frame_len = flen;
    it.hdr_mid[47:32] = header_checksum({it.hdr_lo, it.hdr_mid, it.dst});
    return it;
  endfunction

  function automatic fwd_item_t random_item();
    fwd_item_t it;
    int pick;
    int s;
    int flip;
    logic [7:0] ttl;
    logic [7:0] proto;
    logic [7:0] icmp;
    logic [31:0] dst;
    logic [15:0] flen;
    pick = $urandom_range(99);
    if (pick < 12) begin
      it = noise_item(OP_WRITE);
      if ($urandom_range(4) != 0) it.mask = ~(32'hFFFF_FFFF >> $urandom_range(32));
      it.net = {prefix_pool[$urandom_range(3)], it.net[15:0]};
      if ($urandom_range(2) == 0) it.gw = '0;
      return it;
    end
    if (pick < 17) return noise_item(OP_CLEAR);
    if (pick < 19) return noise_item(OP_UNUSED);

    case ($urandom_range(9))
      0: ttl = 8'd1;
      1: ttl = 8'd0;
      default: ttl = 8'($urandom);
    endcase
    proto = $urandom_range(1) ? PROTO_ICMP : 8'($urandom);
    icmp = $urandom_range(1) ? ICMP_ECHO_REQ : 8'($urandom);
    pick = $urandom_range(9);
    if (pick < 3) begin
      dst = port_addr_m[$urandom_range(3)];
    end else if (pick < 8) begin
      s = $urandom_range(ROUTES - 1);
      dst = (rt_net[s] & rt_mask[s]) | ($urandom & ~rt_mask[s]);
    end else begin
      dst = $urandom;
    end
    flen = ($urandom_range(9) == 0) ? 16'($urandom_range(33)) : 16'($urandom_range(65535, 34));
    it = make_packet(ttl, proto, icmp, dst, flen);
    if ($urandom_range(11) == 0) begin
      flip = 32 + $urandom_range(15);
      it.hdr_mid[flip] = ~it.hdr_mid[flip];
    end
    return it;
  endfunction

  task automatic test_early_drops();
    fwd_item_t it;
    send_item(make_packet(8'd64, 8'd17, 8'd0, 32'hC633_6401, 16'd34));
    send_item(make_packet(8'd64, 8'd17, 8'd0, 32'hC633_6401, 16'd0));
    send_item(make_packet(8'd64, PROTO_ICMP, ICMP_ECHO_REQ, 32'hC633_6402, MIN_FRAME - 16'd1));
    it = make_packet(8'd64, 8'd6, 8'd0, 32'hC633_6403, 16'hFFFF);
    it.hdr_mid[32] = ~it.hdr_mid[32];
    send_item(it);
  endtask

  task automatic test_ttl_expiry();
    send_item(make_packet(8'd1, 8'd17, 8'd0, 32'h0808_0808, 16'd60));
    // A TTL of zero wraps to 255 and carries on to the route lookup.
    send_item(make_packet(8'd0, 8'd17, 8'd0, 32'h0808_0808, 16'd60));
  endtask

  task automatic test_local_delivery();
    wait_for_quiet();
    write_register(REG_PORT_ADDR_0, 32'hC0A8_0001);
    write_register(REG_PORT_ADDR_1, 32'h0A00_0001);
    write_register(REG_PORT_ADDR_2, 32'hFFFF_FFFF);
    write_register(REG_PORT_ADDR_3, 32'h0000_0000);
    send_item(make_packet(8'd64, PROTO_ICMP, ICMP_ECHO_REQ, 32'hFFFF_FFFF, 16'd98));
    send_item(make_packet(8'd1, PROTO_ICMP, 8'd0, 32'hC0A8_0001, 16'd98));
    send_item(make_packet(8'd0, 8'd6, ICMP_ECHO_REQ, 32'h0A00_0001, 16'd60));

    // No port counts as local, so the echo request is routed instead.
    wait_for_quiet();
    write_register(REG_PORTS_IN_USE, 32'd0);
    send_item(make_packet(8'd64, PROTO_ICMP, ICMP_ECHO_REQ, 32'hFFFF_FFFF, 16'd98));

    // Values above four count as four; junk in the upper data bits is dropped.
    wait_for_quiet();
    write_register(REG_PORTS_IN_USE, 32'hFFFF_FFFF);
    write_register(REG_UNMAPPED, 32'd1);
    send_item(make_packet(8'd64, 8'd17, 8'd0, 32'h0000_0000, 16'd60));

    wait_for_quiet();
    write_register(REG_PORTS_IN_USE, 32'd3);
    send_item(make_packet(8'd64, 8'd17, 8'd0, 32'h0000_0000, 16'd60));

    wait_for_quiet();
    write_register(REG_PORTS_IN_USE, 32'd1);
    write_register(REG_PORTS_IN_USE, {29'd0, PORTS_IN_USE_RESET});
  endtask

  task automatic test_route_lookup();
    send_item(route_item(4'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 2'd1));
    send_item(route_item(4'd5, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_00FE, 2'd2));
    send_item(route_item(4'd9, 32'h0A01_FFFF, 32'hFFFF_0000, 32'hC000_0201, 2'd3));
    send_item(route_item(4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 2'd0));
    send_item(route_item(4'd3, 32'h0808_0808, 32'hFFFF_FFFF, 32'h0000_0000, 2'd2));
    send_item(make_packet(8'd64, 8'd6, 8'd0, 32'h0A02_0304, 16'd1514));
    send_item(make_packet(8'd64, 8'd6, 8'd0, 32'h0A01_0203, 16'd1514));
    send_item(make_packet(8'd255, 8'd17, 8'd0, 32'h0808_0808, 16'd1514));
    send_item(make_packet(8'd2, 8'd17, 8'd0, 32'h0102_0304, 16'd1514));
    send_item(route_clear_of(4'd9));
    send_item(make_packet(8'd64, 8'd6, 8'd0, 32'h0A01_0203, 16'd1514));
  endtask

  task automatic test_unused_opcode();
    send_item(noise_item(OP_UNUSED));
    wait_for_quiet();
  endtask

  task automatic test_register_settings();
    logic [31:0] value;
    wait_for_quiet();
    for (int r = 0; r < 4; r++) begin
      case ($urandom_range(4))
        0: value = '0;
        1: value = '1;
        default: value = $urandom;
      endcase
      write_register(REG_PORT_ADDR_0 + 3'(r), value);
    end
    value = $urandom;
    value[2:0] = 3'($urandom_range(7));
    write_register(REG_PORTS_IN_USE, value);
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    for (int n = 0; n < count; n++) begin
      send_item(random_item());
      if (with_gaps) begin
        if ($urandom_range(3) == 0) pause_sender($urandom_range(11, 1));
        else if ($urandom_range(49) == 0) wait_for_quiet();
      end
    end
  endtask

  initial begin
    for (int p = 0; p < 4; p++) port_addr_m[p] = '0;
    ports_in_use_m = PORTS_IN_USE_RESET;
    for (int i = 0; i < ROUTES; i++) begin
      rt_net[i] = '0;
      rt_mask[i] = '0;
      rt_gw[i] = '0;
      rt_port[i] = '0;
      rt_valid[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) prefix_pool[i] = 16'($urandom);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_early_drops();
    test_ttl_expiry();
    test_local_delivery();
    test_route_lookup();
    test_unused_opcode();

    for (int phase = 0; phase < 3; phase++) begin
      test_register_settings();
      test_random_traffic(110, 1'b1);
    end
    test_register_settings();
    test_random_traffic(120, 1'b0);

    wait_for_quiet();
    if (mismatch_count == 0) begin
      $display("ipv4_forward_decision_core regression: pass");
    end else begin
      $display("ipv4_forward_decision_core regression: fail");
    end
    $finish;
  end

endmodule
